// File: sv/atpr_pkg.sv
// shared constants, types and helpers of the accelerometer tilt pitch/roll core
`default_nettype none

package atpr_pkg;

  localparam int ANGLE_STAGES  = 16;
  localparam int TABLE_LEN     = 24;
  localparam int CORDIC_STAGES = (ANGLE_STAGES > TABLE_LEN) ? TABLE_LEN : ANGLE_STAGES;

  localparam int AW          = 16;
  localparam int SQW         = 32;
  localparam int ROOTW       = 32;
  localparam int REMW        = ROOTW + 2;
  localparam int SQRT_STEPS  = ROOTW;
  localparam int CW          = 36;
  localparam int ZW          = 32;
  localparam int PRESCALE    = 16;
  localparam int ROUND_SHIFT = 16;
  localparam int PW          = 15;
  localparam int RW          = 16;
  localparam int IN_TDATA_W  = 3 * AW;
  localparam int OUT_TDATA_W = ((PW + RW + 7) / 8) * 8;

  localparam int PITCH_MAX = 11520;
  localparam int ROLL_MAX  = 23040;

  localparam logic signed [ZW-1:0] DEG90 = 32'sd754974720;
  localparam logic [ZW:0] ROUND_HALF = (ZW+1)'(1) << (ROUND_SHIFT - 1);

  // atan(2^-i) in 2^-23 degree
  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd377487360, 32'sd222843801, 32'sd117744544, 32'sd59768969,
    32'sd30000467,  32'sd15014858,  32'sd7509261,   32'sd3754860,
    32'sd1877459,   32'sd938733,    32'sd469367,    32'sd234683,
    32'sd117342,    32'sd58671,     32'sd29335,     32'sd14668,
    32'sd7334,      32'sd3667,      32'sd1833,      32'sd917,
    32'sd458,       32'sd229,       32'sd115,       32'sd57
  };

  typedef struct packed {
    logic signed [AW-1:0] ax;
    logic signed [AW-1:0] ay;
    logic signed [AW-1:0] az;
    logic [SQW-2:0]       ay2;
    logic [SQW-2:0]       az2;
  } mul_stage_t;

  typedef struct packed {
    logic signed [AW-1:0] ax;
    logic signed [AW-1:0] ay;
    logic signed [AW-1:0] az;
    logic [SQW-1:0]       sq;
    logic [REMW-1:0]      rem;
    logic [ROOTW-1:0]     root;
  } sqrt_stage_t;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [ZW-1:0] pz;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic signed [ZW-1:0] rz;
    logic                 roll_zero;
    logic                 roll_neg;
    logic                 pitch_zero;
  } cordic_stage_t;

  typedef struct packed {
    logic signed [PW-1:0] pitch;
    logic signed [RW-1:0] roll;
  } result_t;

  // round to nearest, ties away from zero, then clamp to +-lim
  function automatic logic signed [RW-1:0] round_angle(input logic signed [ZW-1:0] acc,
                                                       input logic [RW-2:0] lim);
    logic [ZW-1:0]            mag;
    logic [ZW:0]              sum;
    logic [ZW-ROUND_SHIFT:0]  r;
    logic [RW-2:0]            rc;
    mag = acc[ZW-1] ? (~acc + 1'b1) : acc;
    sum = {1'b0, mag} + ROUND_HALF;
    r   = sum[ZW:ROUND_SHIFT];
    rc  = (r > (ZW-ROUND_SHIFT+1)'(lim)) ? lim : r[RW-2:0];
    return acc[ZW-1] ? -$signed({1'b0, rc}) : $signed({1'b0, rc});
  endfunction

endpackage

`default_nettype wire

// File: sv/accel_tilt_pitch_roll_core.sv
// top level: pipelined pitch and roll from one three-axis accelerometer item
//
// Takes one raw sample (x, y, z, signed 16 bit) per cycle while the skid stage is empty, and
// returns pitch and roll in 1/128 degree. Roll is atan2(y, z); pitch is atan2(-x,
// sqrt(y^2 + z^2)). The magnitude comes from an exact 32-step restoring square root, one
// root bit per stage, and both angles from a vectoring CORDIC with one micro-rotation per
// stage for each channel. Each item passes the input product register, the square root
// chain, the CORDIC chain and the output register in that order. The output register's
// one-entry skid stage lets the block keep accepting while a result waits; input ready
// drops only once the skid stage is full.
`default_nettype none

module accel_tilt_pitch_roll_core
  import atpr_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output      logic                   s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // accel_x, accel_y, accel_z
  output      logic                   m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // pitch_angle, roll_angle, zero pad
);

  logic en;

  logic signed [AW-1:0]   in_x, in_y, in_z;
  logic signed [2*AW-1:0] y_sq, z_sq;

  logic       ma_valid_q;
  mul_stage_t ma_q, ma_d;

  logic [SQRT_STEPS:0] sr_valid_q;
  sqrt_stage_t         sr_q [SQRT_STEPS+1];
  sqrt_stage_t         sr_d [SQRT_STEPS+1];
  logic [2*SQW-1:0]    rad   [SQRT_STEPS];
  logic [REMW-1:0]     trial [SQRT_STEPS];
  logic [REMW-1:0]     test  [SQRT_STEPS];

  logic [CORDIC_STAGES:0] cd_valid_q;
  cordic_stage_t          cd_q [CORDIC_STAGES+1];
  cordic_stage_t          cd_d [CORDIC_STAGES+1];

  logic signed [CW-1:0] ax_w, ay_w, az_w;
  logic signed [RW-1:0] pitch_full, roll_full;

  result_t res_d, out_q, skid_q;
  logic    m_valid_q, skid_valid_q, take_last;

  assign en              = !skid_valid_q;
  assign s_axis_tready_o = en;
  assign take_last       = en && cd_valid_q[CORDIC_STAGES];

  assign in_x = s_axis_tdata_i[AW-1:0];
  assign in_y = s_axis_tdata_i[2*AW-1:AW];
  assign in_z = s_axis_tdata_i[3*AW-1:2*AW];
  assign y_sq = in_y * in_y;
  assign z_sq = in_z * in_z;

  always_comb begin
    ma_d.ax  = in_x;
    ma_d.ay  = in_y;
    ma_d.az  = in_z;
    ma_d.ay2 = y_sq[SQW-2:0];
    ma_d.az2 = z_sq[SQW-2:0];
  end

  // square root, one root bit per stage
  always_comb begin
    sr_d[0].ax   = ma_q.ax;
    sr_d[0].ay   = ma_q.ay;
    sr_d[0].az   = ma_q.az;
    sr_d[0].sq   = {1'b0, ma_q.ay2} + {1'b0, ma_q.az2};
    sr_d[0].rem  = '0;
    sr_d[0].root = '0;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      rad[k]   = {sr_q[k].sq, {SQW{1'b0}}};
      trial[k] = {sr_q[k].rem[REMW-3:0], rad[k][2*SQW-1-2*k -: 2]};
      test[k]  = {sr_q[k].root, 2'b01};
      sr_d[k+1] = sr_q[k];
      if (trial[k] >= test[k]) begin
        sr_d[k+1].rem  = trial[k] - test[k];
        sr_d[k+1].root = {sr_q[k].root[ROOTW-2:0], 1'b1};
      end else begin
        sr_d[k+1].rem  = trial[k];
        sr_d[k+1].root = {sr_q[k].root[ROOTW-2:0], 1'b0};
      end
    end
  end

  assign ax_w = CW'($signed(sr_q[SQRT_STEPS].ax)) <<< PRESCALE;
  assign ay_w = CW'($signed(sr_q[SQRT_STEPS].ay)) <<< PRESCALE;
  assign az_w = CW'($signed(sr_q[SQRT_STEPS].az)) <<< PRESCALE;

  // quadrant set-up and micro-rotations
  always_comb begin
    cd_d[0].px         = $signed({{(CW-ROOTW){1'b0}}, sr_q[SQRT_STEPS].root});
    cd_d[0].py         = -ax_w;
    cd_d[0].pz         = '0;
    cd_d[0].roll_zero  = (sr_q[SQRT_STEPS].ay == '0);
    cd_d[0].roll_neg   = sr_q[SQRT_STEPS].az[AW-1];
    cd_d[0].pitch_zero = (sr_q[SQRT_STEPS].ax == '0) && (sr_q[SQRT_STEPS].root == '0);
    if (sr_q[SQRT_STEPS].az[AW-1]) begin
      if (!sr_q[SQRT_STEPS].ay[AW-1]) begin
        cd_d[0].rx = ay_w;
        cd_d[0].ry = -az_w;
        cd_d[0].rz = DEG90;
      end else begin
        cd_d[0].rx = -ay_w;
        cd_d[0].ry = az_w;
        cd_d[0].rz = -DEG90;
      end
    end else begin
      cd_d[0].rx = az_w;
      cd_d[0].ry = ay_w;
      cd_d[0].rz = '0;
    end
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      cd_d[k+1] = cd_q[k];
      if (!cd_q[k].py[CW-1]) begin
        cd_d[k+1].px = cd_q[k].px + ($signed(cd_q[k].py) >>> k);
        cd_d[k+1].py = cd_q[k].py - ($signed(cd_q[k].px) >>> k);
        cd_d[k+1].pz = cd_q[k].pz + ATAN_TAB[k];
      end else begin
        cd_d[k+1].px = cd_q[k].px - ($signed(cd_q[k].py) >>> k);
        cd_d[k+1].py = cd_q[k].py + ($signed(cd_q[k].px) >>> k);
        cd_d[k+1].pz = cd_q[k].pz - ATAN_TAB[k];
      end
      if (!cd_q[k].ry[CW-1]) begin
        cd_d[k+1].rx = cd_q[k].rx + ($signed(cd_q[k].ry) >>> k);
        cd_d[k+1].ry = cd_q[k].ry - ($signed(cd_q[k].rx) >>> k);
        cd_d[k+1].rz = cd_q[k].rz + ATAN_TAB[k];
      end else begin
        cd_d[k+1].rx = cd_q[k].rx - ($signed(cd_q[k].ry) >>> k);
        cd_d[k+1].ry = cd_q[k].ry + ($signed(cd_q[k].rx) >>> k);
        cd_d[k+1].rz = cd_q[k].rz - ATAN_TAB[k];
      end
    end
  end

  assign pitch_full = round_angle(cd_q[CORDIC_STAGES].pz, (RW-1)'(PITCH_MAX));
  assign roll_full  = round_angle(cd_q[CORDIC_STAGES].rz, (RW-1)'(ROLL_MAX));

  always_comb begin
    res_d.pitch = cd_q[CORDIC_STAGES].pitch_zero ? '0 : pitch_full[PW-1:0];
    if (cd_q[CORDIC_STAGES].roll_zero) begin
      res_d.roll = cd_q[CORDIC_STAGES].roll_neg ? RW'(ROLL_MAX) : '0;
    end else begin
      res_d.roll = roll_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ma_valid_q   <= 1'b0;
      sr_valid_q   <= '0;
      cd_valid_q   <= '0;
      m_valid_q    <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (en) begin
        ma_valid_q <= s_axis_tvalid_i;
        sr_valid_q <= {sr_valid_q[SQRT_STEPS-1:0], ma_valid_q};
        cd_valid_q <= {cd_valid_q[CORDIC_STAGES-1:0], sr_valid_q[SQRT_STEPS]};
      end
      if (skid_valid_q) begin
        if (m_axis_tready_i) begin
          skid_valid_q <= 1'b0;
        end
      end else if (take_last) begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma_q <= ma_d;
      for (int k = 0; k <= SQRT_STEPS; k++) begin
        sr_q[k] <= sr_d[k];
      end
      for (int k = 0; k <= CORDIC_STAGES; k++) begin
        cd_q[k] <= cd_d[k];
      end
    end
    if (skid_valid_q && m_axis_tready_i) begin
      out_q <= skid_q;
    end else if (take_last && (!m_valid_q || m_axis_tready_i)) begin
      out_q <= res_d;
    end
    if (take_last && m_valid_q && !m_axis_tready_i) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-PW-RW){1'b0}}, out_q.roll, out_q.pitch};

  a_skid_implies_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> m_valid_q)
    else $error("skid stage holds an item while output is empty");

  a_last_moves_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cd_valid_q[CORDIC_STAGES] && !skid_valid_q) |=> m_valid_q)
    else $error("finished item did not reach the output");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && m_axis_tready_i) |=> !skid_valid_q)
    else $error("skid stage did not drain");

  a_pitch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (int'(out_q.pitch) <= PITCH_MAX && int'(out_q.pitch) >= -PITCH_MAX))
    else $error("pitch out of range");

endmodule

`default_nettype wire

// File: tb/sv/accel_tilt_pitch_roll_core_tb.sv
// tilt core testbench: corner cases and a random stream against a bit-exact angle predictor
module accel_tilt_pitch_roll_core_tb
  import atpr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM     = 1750;
  localparam int DRAIN_CYCLES = 36 + CORDIC_STAGES + 20;
  localparam logic signed [63:0] QUARTER_TURN = 64'sd754974720;
  localparam logic signed [63:0] HALF_LSB     = 64'sd32768;

  typedef struct packed {
    logic signed [AW-1:0] az;
    logic signed [AW-1:0] ay;
    logic signed [AW-1:0] ax;
  } accel_t;

  // atan(2^-i) in 2^-23 degree
  localparam logic signed [63:0] ARCTAN_STEP [24] = '{
    64'sd377487360, 64'sd222843801, 64'sd117744544, 64'sd59768969,
    64'sd30000467,  64'sd15014858,  64'sd7509261,   64'sd3754860,
    64'sd1877459,   64'sd938733,    64'sd469367,    64'sd234683,
    64'sd117342,    64'sd58671,     64'sd29335,     64'sd14668,
    64'sd7334,      64'sd3667,      64'sd1833,      64'sd917,
    64'sd458,       64'sd229,       64'sd115,       64'sd57
  };

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_tready;
  accel_t                 s_data = '0;
  logic                   m_valid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  accel_t  sample_q[$];
  result_t angle_q[$];
  int      errors = 0;
  int      send_gap = 0;
  int      stall_left = 0;
  bit      src_burst = 1'b0;
  bit      sink_burst = 1'b0;

  accel_tilt_pitch_roll_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring cordic, angle of (x, y) in 2^-23 degree
  function automatic logic signed [63:0] cordic_angle(input logic signed [63:0] x,
                                                      input logic signed [63:0] y);
    logic signed [63:0] z;
    logic signed [63:0] t;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    int                 n;
    z = '0;
    n = (ANGLE_STAGES > 24) ? 24 : ANGLE_STAGES;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = QUARTER_TURN;
      end else begin
        x = -y;
        y = t;
        z = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic logic signed [63:0] round_clamp(input logic signed [63:0] acc,
                                                     input int lim);
    logic signed [63:0] r;
    if (acc >= 0) r = (acc + HALF_LSB) >>> ROUND_SHIFT;
    else          r = -((-acc + HALF_LSB) >>> ROUND_SHIFT);
    if (r > lim)  r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic result_t predict_tilt(input accel_t a);
    logic signed [63:0] x64;
    logic signed [63:0] y64;
    logic signed [63:0] z64;
    logic signed [63:0] sq;
    logic signed [63:0] mag;
    logic signed [63:0] nx;
    logic signed [63:0] pitch;
    logic signed [63:0] roll;
    result_t            res;
    x64 = a.ax;
    y64 = a.ay;
    z64 = a.az;
    sq  = y64 * y64 + z64 * z64;
    mag = int_sqrt(sq << 32);
    nx  = -x64;
    if (y64 == 0) roll = (z64 < 0) ? ROLL_MAX : 0;
    else          roll = round_clamp(cordic_angle(z64 <<< PRESCALE, y64 <<< PRESCALE), ROLL_MAX);
    pitch = '0;
    if (nx != 0 || mag != 0)
      pitch = round_clamp(cordic_angle(mag, nx <<< PRESCALE), PITCH_MAX);
    res.pitch = pitch[PW-1:0];
    res.roll  = roll[RW-1:0];
    return res;
  endfunction

  function automatic void queue_sample(input int x, input int y, input int z);
    accel_t a;
    a.ax = x[AW-1:0];
    a.ay = y[AW-1:0];
    a.az = z[AW-1:0];
    sample_q.push_back(a);
  endfunction

  function automatic logic signed [AW-1:0] rand_axis();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return AW'($urandom);
    if (k < 70) return AW'($urandom_range(0, 8) - 4);
    if (k < 85) begin
      case ($urandom_range(0, 5))
        0:       return -16'sd32768;
        1:       return -16'sd32767;
        2:       return -16'sd1;
        3:       return 16'sd1;
        4:       return 16'sd32767;
        default: return 16'sd0;
      endcase
    end
    if (k < 93) return AW'($urandom_range(0, 2047) - 1024);
    return '0;
  endfunction

  // mostly short gaps, a few long ones, none at all in burst stretches
  function automatic int pick_gap(input bit burst);
    int k;
    if (burst) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin : drive
    logic   v;
    accel_t nxt;
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else begin
      v   = s_valid;
      nxt = s_data;
      if (s_valid && s_tready) begin
        angle_q.push_back(predict_tilt(s_data));
        v = 1'b0;
      end
      if (!v) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_q.size() != 0) begin
          nxt = sample_q.pop_front();
          v = 1'b1;
          send_gap = pick_gap(src_burst);
          if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
        end
      end
      s_valid <= v;
      s_data  <= nxt;
    end
  end

  always @(posedge clk_i) begin : watch
    result_t want;
    result_t got;
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (m_valid && m_tready) begin
        got.pitch = m_tdata[PW-1:0];
        got.roll  = m_tdata[PW+RW-1:PW];
        if (angle_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected item: pitch %0d roll %0d", got.pitch, got.roll);
        end else begin
          want = angle_q.pop_front();
          if (want.pitch != got.pitch || want.roll != got.roll) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: pitch exp %0d got %0d, roll exp %0d got %0d",
                       want.pitch, got.pitch, want.roll, got.roll);
          end
        end
      end
      if ($urandom_range(0, 255) == 0) sink_burst = !sink_burst;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        stall_left = pick_gap(sink_burst);
        if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    // extremes and corner directions
    queue_sample(0, 0, 0);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, 32767, 32767);
    queue_sample(32767, -32768, 32767);
    queue_sample(-32768, 32767, -32768);
    queue_sample(0, 0, 16384);
    queue_sample(0, 0, -16384);
    queue_sample(0, 0, -1);
    queue_sample(0, 16384, 0);
    queue_sample(0, -16384, 0);
    queue_sample(0, 1, -32768);
    queue_sample(0, -1, -32768);
    queue_sample(0, 1000, -1000);
    queue_sample(0, -1000, -1000);
    queue_sample(-32768, 0, 0);
    queue_sample(32767, 0, 0);
    queue_sample(1, 0, 0);
    queue_sample(-1, 0, 0);
    queue_sample(-32768, 1, 0);
    queue_sample(16384, 0, 16384);
    queue_sample(-5000, 12000, 9000);
    queue_sample(1, 1, 1);
    queue_sample(-1, -1, -1);
    for (int i = 0; i < N_RANDOM; i++) begin
      accel_t a;
      a.ax = rand_axis();
      a.ay = rand_axis();
      a.az = rand_axis();
      sample_q.push_back(a);
    end
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    while (sample_q.size() != 0 || s_valid) @(posedge clk_i);
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    errors += angle_q.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
sv/atpr_pkg.sv
sv/accel_tilt_pitch_roll_core.sv
tb/sv/accel_tilt_pitch_roll_core_tb.sv
